[rtl/ntps_pkg.sv]
// Shared constants, types and state codes for the prime table sieve.
`timescale 1ns / 1ps
package ntps_pkg;
    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KNOWN_W     = ADDR_W + 1;
    localparam int PRIME_W     = 20;
    localparam int CAND_W      = PRIME_W + 1;
    localparam int INDEX_W     = 21;
    localparam int STEP_W      = $clog2(PRIME_W + 1);

    localparam logic [CAND_W-1:0] PRIME_LIMIT = CAND_W'((64'd1 << PRIME_W) - 64'd1);

    // Control and status between the sequencer and the remainder unit
    typedef struct packed {
        logic               start;
        logic [PRIME_W-1:0] dividend;
        logic [PRIME_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } mod_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HIT,
        ST_NEXT,
        ST_RD,
        ST_LOAD,
        ST_SQ,
        ST_DIV,
        ST_APPEND,
        ST_DONE
    } seq_state_t;
endpackage

[rtl/nth_prime_table_sieve_unit.sv]
// Top level of the prime table sieve: request sequencer, table and trial division.
`timescale 1ns / 1ps
// Each input beat asks for the prime at a zero-based index (0 gives 2). An index
// already in the table is answered through one read of the table
// RAM. An index beyond the table extends it one odd candidate at a time by trial
// division with the known primes up to the candidate's square root; each trial
// divisor costs one RAM read, one square compare and a bit-serial remainder, so
// a miss costs the sum of that over all candidates
// between the last known prime and the requested one. An index at or above 65536
// returns capacity_error with a zero value. One request is worked on at a time;
// a finished result waits in an output register while the next beat is taken.
module nth_prime_table_sieve_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] prime_value
    output logic        m_tuser    // [0] capacity_error
);
    import ntps_pkg::*;

    seq_state_t         state_reg, state_next;
    logic [KNOWN_W-1:0] known_reg, known_next;
    logic [PRIME_W-1:0] last_reg, last_next;
    logic [CAND_W-1:0]  cand_reg, cand_next;
    logic [KNOWN_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [PRIME_W-1:0] div_reg, div_next;
    logic [PRIME_W-1:0] res_val_reg, res_val_next;
    logic               res_err_reg, res_err_next;
    logic               m_valid_reg, m_valid_next;
    logic [PRIME_W-1:0] m_val_reg, m_val_next;
    logic               m_err_reg, m_err_next;
    logic [ADDR_W-1:0]  raddr_q_reg;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [PRIME_W-1:0] ram_rdata;
    logic [PRIME_W-1:0] rd_value;
    logic [2*PRIME_W-1:0] div_sq;
    logic [INDEX_W-1:0] s_index;
    logic               s_fire;
    mod_req_t           mod_req;
    mod_rsp_t           mod_rsp;

    ntps_ram #(.DEPTH(TABLE_DEPTH), .DATA_W(PRIME_W)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (known_reg[ADDR_W-1:0]),
        .wdata (cand_reg[PRIME_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ntps_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    assign s_index  = s_tdata[INDEX_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign div_sq   = div_reg * div_reg;

    // Entries 0 and 1 are never written; they read as 2 and 3
    always_comb begin
        if (raddr_q_reg == ADDR_W'(0)) begin
            rd_value = PRIME_W'(2);
        end else if (raddr_q_reg == ADDR_W'(1)) begin
            rd_value = PRIME_W'(3);
        end else begin
            rd_value = ram_rdata;
        end
    end

    // Sequencer: next state and datapath
    always_comb begin
        state_next   = state_reg;
        known_next   = known_reg;
        last_next    = last_reg;
        cand_next    = cand_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        div_next     = div_reg;
        res_val_next = res_val_reg;
        res_err_next = res_err_reg;
        m_valid_next = m_valid_reg;
        m_val_next   = m_val_reg;
        m_err_next   = m_err_reg;
        ram_we       = 1'b0;
        ram_raddr    = pos_reg[ADDR_W-1:0];
        mod_req.start    = 1'b0;
        mod_req.dividend = cand_reg[PRIME_W-1:0];
        mod_req.divisor  = div_reg;

        // Drop the output beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                ram_raddr = s_index[ADDR_W-1:0];
                if (s_fire) begin
                    idx_next = s_index[ADDR_W-1:0];
                    if (s_index >= INDEX_W'(TABLE_DEPTH)) begin
                        res_val_next = '0;
                        res_err_next = 1'b1;
                        state_next   = ST_DONE;
                    end else if (KNOWN_W'(s_index) < known_reg) begin
                        state_next = ST_HIT;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_HIT: begin
                res_val_next = rd_value;
                res_err_next = 1'b0;
                state_next   = ST_DONE;
            end
            ST_NEXT: begin
                // Advance to the next odd candidate
                cand_next = CAND_W'(last_reg) + CAND_W'(2);
                pos_next  = KNOWN_W'(1);
                if (known_reg >= KNOWN_W'(TABLE_DEPTH) ||
                    (CAND_W'(last_reg) + CAND_W'(2)) > PRIME_LIMIT) begin
                    res_val_next = '0;
                    res_err_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                if (pos_reg >= known_reg) begin
                    state_next = ST_APPEND;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                div_next   = rd_value;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                if (div_sq > (2*PRIME_W)'(cand_reg)) begin
                    state_next = ST_APPEND;
                end else begin
                    mod_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mod_rsp.done) begin
                    if (mod_rsp.rem_zero) begin
                        last_next  = cand_reg[PRIME_W-1:0];
                        state_next = ST_NEXT;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_APPEND: begin
                // Write the survivor and check for the requested index
                ram_we     = 1'b1;
                known_next = known_reg + 1'b1;
                last_next  = cand_reg[PRIME_W-1:0];
                if (KNOWN_W'(idx_reg) == known_reg) begin
                    res_val_next = cand_reg[PRIME_W-1:0];
                    res_err_next = 1'b0;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A composite candidate also moves the search past it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            known_reg   <= KNOWN_W'(2);
            last_reg    <= PRIME_W'(3);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            known_reg   <= known_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg    <= cand_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        div_reg     <= div_next;
        res_val_reg <= res_val_next;
        res_err_reg <= res_err_next;
        m_val_reg   <= m_val_next;
        m_err_reg   <= m_err_next;
        raddr_q_reg <= ram_raddr;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(24-PRIME_W){1'b0}}, m_val_reg};
    assign m_tuser  = m_err_reg;

    // Table count stays within capacity
    a_known_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        known_reg <= KNOWN_W'(TABLE_DEPTH))
        else $error("prime count beyond table capacity");

    // An error beat carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error beat with nonzero value");

    // The remainder unit is only started while idle
    a_mod_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_req.start |-> !mod_rsp.busy)
        else $error("remainder unit restarted while busy");

    // A table write only appends one entry
    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> known_reg == $past(known_reg) + 1'b1)
        else $error("table append did not advance count");
endmodule

[rtl/ntps_ram.sv]
// Synchronous RAM with one write port, one read port and registered read data.
`timescale 1ns / 1ps
module ntps_ram #(
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 20
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end
endmodule

[rtl/ntps_mod.sv]
// Bit-serial remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module ntps_mod (
    input  logic              aclk,
    input  logic              aresetn,
    input  ntps_pkg::mod_req_t req,
    output ntps_pkg::mod_rsp_t rsp
);
    import ntps_pkg::*;

    logic               active_reg, active_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [PRIME_W-1:0] rem_reg, rem_next;
    logic [PRIME_W-1:0] dvd_reg, dvd_next;
    logic [PRIME_W-1:0] dvs_reg, dvs_next;
    logic [PRIME_W:0]   trial;

    // One restoring step per cycle
    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        trial       = {rem_reg, dvd_reg[PRIME_W-1]};
        if (req.start && !active_reg) begin
            active_next = 1'b1;
            cnt_next    = '0;
            rem_next    = '0;
            dvd_next    = req.dividend;
            dvs_next    = req.divisor;
        end else if (active_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = PRIME_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[PRIME_W-1:0];
            end
            dvd_next = {dvd_reg[PRIME_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(PRIME_W - 1)) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = active_reg;
    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (rem_reg == '0);
endmodule
